// File: hw/rtl/rotated_ellipse_bezier_points_defines.svh
// ----------------------------------------------------------------------------
// rotated ellipse bezier points: assertion macros
// concurrent assertion wrappers on clock, with and without reset disable
// ----------------------------------------------------------------------------
`ifndef ROTATED_ELLIPSE_BEZIER_POINTS_DEFINES_SVH
`define ROTATED_ELLIPSE_BEZIER_POINTS_DEFINES_SVH

// checked outside reset
`define REBP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked in every cycle, reset included
`define REBP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// File: hw/rtl/rebp_pkg.sv
// ----------------------------------------------------------------------------
// rebp_pkg
// shared constants, codes and the control point layout table
// ----------------------------------------------------------------------------
package rebp_pkg;

   localparam int unsigned REBP_COORD_WIDTH     = 16;
   localparam int unsigned REBP_TRIG_FRAC_BITS  = 14;
   localparam int unsigned REBP_IDX_WIDTH       = 4;
   localparam logic [REBP_IDX_WIDTH-1:0] REBP_LAST_IDX = 4'd12;
   localparam int unsigned REBP_CSR_INDEX_WIDTH = 1;

   // 0.2761423749 in q0.16, truncated, with a zero sign bit
   localparam int unsigned REBP_K_FRAC = 16;
   localparam logic [16:0] REBP_K_Q16  = 17'd18097;

   typedef enum logic [REBP_CSR_INDEX_WIDTH-1:0] {
      CSR_ROT_COS = 1'b0,
      CSR_ROT_SIN = 1'b1
   } rebp_csr_type;

   typedef enum logic [2:0] {
      XS_LEFT  = 3'd0,
      XS_CXM   = 3'd1,
      XS_CX    = 3'd2,
      XS_CXP   = 3'd3,
      XS_RIGHT = 3'd4
   } rebp_xsel_type;

   typedef enum logic [2:0] {
      YS_TOP    = 3'd0,
      YS_CYM    = 3'd1,
      YS_CY     = 3'd2,
      YS_CYP    = 3'd3,
      YS_BOTTOM = 3'd4
   } rebp_ysel_type;

   typedef struct packed {
      rebp_xsel_type xsel;
      rebp_ysel_type ysel;
   } rebp_layout_type;

   typedef struct packed {
      logic                      valid;
      logic                      last;
      logic [REBP_IDX_WIDTH-1:0] index;
   } rebp_tag_type;

   function automatic rebp_layout_type rebp_layout(input logic [REBP_IDX_WIDTH-1:0] idx);
      rebp_layout_type lay;
      case (idx)
         4'd0:    lay = '{XS_LEFT,  YS_CY};
         4'd1:    lay = '{XS_LEFT,  YS_CYM};
         4'd2:    lay = '{XS_CXM,   YS_TOP};
         4'd3:    lay = '{XS_CX,    YS_TOP};
         4'd4:    lay = '{XS_CXP,   YS_TOP};
         4'd5:    lay = '{XS_RIGHT, YS_CYM};
         4'd6:    lay = '{XS_RIGHT, YS_CY};
         4'd7:    lay = '{XS_RIGHT, YS_CYP};
         4'd8:    lay = '{XS_CXP,   YS_BOTTOM};
         4'd9:    lay = '{XS_CX,    YS_BOTTOM};
         4'd10:   lay = '{XS_CXM,   YS_BOTTOM};
         4'd11:   lay = '{XS_LEFT,  YS_CYP};
         4'd12:   lay = '{XS_LEFT,  YS_CY};
         default: lay = '{XS_CX,    YS_CY};
      endcase
      return lay;
   endfunction

endpackage

// File: hw/rtl/rebp_ifs.sv
// ----------------------------------------------------------------------------
// rebp channel interfaces
// rectangle request channel and control point response channel
// ----------------------------------------------------------------------------
interface rebp_req_if
   import rebp_pkg::*;
#(
   parameter int unsigned COORD_WIDTH = REBP_COORD_WIDTH
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] rect_left;
   logic signed [COORD_WIDTH-1:0] rect_top;
   logic signed [COORD_WIDTH-1:0] rect_right;
   logic signed [COORD_WIDTH-1:0] rect_bottom;

   modport source (
      output valid, rect_left, rect_top, rect_right, rect_bottom,
      input  ready
   );
   modport sink (
      input  valid, rect_left, rect_top, rect_right, rect_bottom,
      output ready
   );
endinterface

interface rebp_rsp_if
   import rebp_pkg::*;
#(
   parameter int unsigned COORD_WIDTH = REBP_COORD_WIDTH
);
   logic                          valid;
   logic                          ready;
   logic [REBP_IDX_WIDTH-1:0]     point_index;
   logic signed [COORD_WIDTH-1:0] out_x;
   logic signed [COORD_WIDTH-1:0] out_y;
   logic                          last_point;

   modport source (
      output valid, point_index, out_x, out_y, last_point,
      input  ready
   );
   modport sink (
      input  valid, point_index, out_x, out_y, last_point,
      output ready
   );
endinterface

// File: hw/rtl/rebp_rotate.sv
// ----------------------------------------------------------------------------
// rebp_rotate
// rotation pipeline: multiply, sum with rounding, truncate and saturate
// ----------------------------------------------------------------------------
module rebp_rotate
   import rebp_pkg::*;
#(
   parameter int unsigned COORD_WIDTH    = REBP_COORD_WIDTH,
   parameter int unsigned TRIG_FRAC_BITS = REBP_TRIG_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [TRIG_FRAC_BITS+1:0]   rot_cos,
   input  logic signed [TRIG_FRAC_BITS+1:0]   rot_sin,
   input  rebp_tag_type                       pt_tag,
   input  logic signed [COORD_WIDTH:0]        pt_dx,
   input  logic signed [COORD_WIDTH:0]        pt_dy,
   input  logic signed [COORD_WIDTH-1:0]      pt_cx,
   input  logic signed [COORD_WIDTH-1:0]      pt_cy,
   output logic                               adv,
   rebp_rsp_if.source                         rsp_chan
);
   localparam int unsigned CW = COORD_WIDTH;
   localparam int unsigned DW = COORD_WIDTH + 1;
   localparam int unsigned TW = TRIG_FRAC_BITS + 2;
   localparam int unsigned PW = DW + TW;
   localparam int unsigned AW = CW + TRIG_FRAC_BITS + 5;
   localparam int unsigned QW = AW - TRIG_FRAC_BITS;
   localparam logic [AW-1:0] HALF = AW'(1) << (TRIG_FRAC_BITS - 1);
   localparam logic [AW-1:0] FRAC_MASK = (AW'(1) << TRIG_FRAC_BITS) - AW'(1);

   function automatic logic [CW-1:0] sat_coord(input logic [QW-1:0] q);
      logic [QW-CW:0] top;
      top = q[QW-1:CW-1];
      if ((&top) || (~|top)) begin
         return q[CW-1:0];
      end else if (q[QW-1]) begin
         return {1'b1, {(CW-1){1'b0}}};
      end else begin
         return {1'b0, {(CW-1){1'b1}}};
      end
   endfunction

   // multiply stage
   rebp_tag_type           m_tag_ff;
   logic signed [PW-1:0]   m_xc_ff, m_ys_ff, m_xs_ff, m_yc_ff;
   logic signed [CW-1:0]   m_cx_ff, m_cy_ff;

   // sum stage
   rebp_tag_type           s_tag_ff;
   logic [AW-1:0]          s_ax_ff, s_ay_ff;

   // output stage
   rebp_tag_type           o_tag_ff;
   logic [CW-1:0]          o_x_ff, o_y_ff;

   logic [AW-1:0]          adj_x, adj_y;

   assign adv = !o_tag_ff.valid || rsp_chan.ready;

   assign adj_x = s_ax_ff + (s_ax_ff[AW-1] ? FRAC_MASK : '0);
   assign adj_y = s_ay_ff + (s_ay_ff[AW-1] ? FRAC_MASK : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_tag_ff <= '0;
         s_tag_ff <= '0;
         o_tag_ff <= '0;
      end else if (adv) begin
         m_tag_ff <= pt_tag;
         s_tag_ff <= m_tag_ff;
         o_tag_ff <= s_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_xc_ff <= pt_dx * rot_cos;
         m_ys_ff <= pt_dy * rot_sin;
         m_xs_ff <= pt_dx * rot_sin;
         m_yc_ff <= pt_dy * rot_cos;
         m_cx_ff <= pt_cx;
         m_cy_ff <= pt_cy;

         s_ax_ff <= (AW'(m_cx_ff) << TRIG_FRAC_BITS) + AW'(m_xc_ff) + AW'(m_ys_ff) + HALF;
         s_ay_ff <= (AW'(m_cy_ff) << TRIG_FRAC_BITS) - AW'(m_xs_ff) + AW'(m_yc_ff) + HALF;

         o_x_ff <= sat_coord(adj_x[TRIG_FRAC_BITS +: QW]);
         o_y_ff <= sat_coord(adj_y[TRIG_FRAC_BITS +: QW]);
      end
   end

   assign rsp_chan.valid       = o_tag_ff.valid;
   assign rsp_chan.point_index = o_tag_ff.index;
   assign rsp_chan.last_point  = o_tag_ff.last;
   assign rsp_chan.out_x       = o_x_ff;
   assign rsp_chan.out_y       = o_y_ff;

endmodule

// File: hw/rtl/rotated_ellipse_bezier_points.sv
// ----------------------------------------------------------------------------
// rotated_ellipse_bezier_points
// rectangle in, 13 rotated cubic bezier control points of the ellipse out
//
//   channel   dir   handshake      word
//   req_chan  in    valid / ready  rect_left, rect_top, rect_right, rect_bottom
//   rsp_chan  out   valid / ready  point_index, out_x, out_y, last_point
//   csr       in    csr_we         csr_index, csr_wdata (rot_cos, rot_sin)
//
// the point sequencer issues one point per cycle unless the response channel stalls;
// the next rectangle waits in the input stage; points pass geometry, point and rotate stages
// synchronous reset empties the pipeline and sets rot_cos to 1.0, rot_sin to 0
// a response word left waiting holds every stage; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module rotated_ellipse_bezier_points
   import rebp_pkg::*;
#(
   parameter int unsigned COORD_WIDTH    = REBP_COORD_WIDTH,
   parameter int unsigned TRIG_FRAC_BITS = REBP_TRIG_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   rebp_req_if.sink                         req_chan,
   rebp_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [REBP_CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [TRIG_FRAC_BITS+1:0]        csr_wdata
);
   localparam int unsigned CW  = COORD_WIDTH;
   localparam int unsigned DW  = COORD_WIDTH + 1;
   localparam int unsigned TW  = TRIG_FRAC_BITS + 2;
   localparam int unsigned KW  = $bits(REBP_K_Q16);
   localparam int unsigned OPW = DW + KW;
   localparam logic [OPW-1:0] K_BIAS = (OPW'(1) << REBP_K_FRAC) - OPW'(1);

   // rotation registers
   logic signed [TW-1:0] cos_ff, sin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff <= {2'b01, {TRIG_FRAC_BITS{1'b0}}};
         sin_ff <= '0;
      end else if (csr_we) begin
         case (rebp_csr_type'(csr_index))
            CSR_ROT_COS: cos_ff <= csr_wdata;
            CSR_ROT_SIN: sin_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic adv;

   // input stage
   logic            in_vld_ff, in_vld_in, in_free, req_take;
   logic [CW-1:0]   in_l_ff, in_t_ff, in_r_ff, in_b_ff;
   logic [DW-1:0]   in_w_ff, in_h_ff, in_sx_ff, in_sy_ff;

   // geometry stage, held while its points are issued
   logic                       geo_vld_ff, geo_vld_in, geo_free;
   logic [REBP_IDX_WIDTH-1:0]  seq_idx_ff, seq_idx_in;
   logic [CW-1:0]              geo_l_ff, geo_t_ff, geo_r_ff, geo_b_ff;
   logic [CW-1:0]              geo_cx_ff, geo_cy_ff;
   logic [DW-1:0]              geo_ox_ff, geo_oy_ff;
   logic [OPW-1:0]             ox_prod, oy_prod, ox_adj, oy_adj;
   logic [DW-1:0]              sx_adj, sy_adj;
   logic                       seq_last;

   // point stage
   rebp_tag_type               pt_tag_ff;
   logic signed [DW-1:0]       pt_dx_ff, pt_dy_ff;
   logic signed [CW-1:0]       pt_cx_ff, pt_cy_ff;
   rebp_layout_type            lay;
   logic [DW-1:0]              dx, dy;

   assign seq_last = (seq_idx_ff == REBP_LAST_IDX);
   assign geo_free = !geo_vld_ff || (adv && seq_last);
   assign in_free  = !in_vld_ff || geo_free;
   assign req_chan.ready = in_free;
   assign req_take = req_chan.valid && in_free;
   assign in_vld_in  = in_free ? req_chan.valid : in_vld_ff;
   assign geo_vld_in = geo_free ? in_vld_ff : geo_vld_ff;

   always_comb begin
      seq_idx_in = seq_idx_ff;
      if (adv && geo_vld_ff) begin
         seq_idx_in = seq_last ? '0 : seq_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         geo_vld_ff <= 1'b0;
         seq_idx_ff <= '0;
         pt_tag_ff  <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         geo_vld_ff <= geo_vld_in;
         seq_idx_ff <= seq_idx_in;
         if (adv) begin
            pt_tag_ff <= '{valid: geo_vld_ff, last: seq_last, index: seq_idx_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_l_ff  <= req_chan.rect_left;
         in_t_ff  <= req_chan.rect_top;
         in_r_ff  <= req_chan.rect_right;
         in_b_ff  <= req_chan.rect_bottom;
         in_w_ff  <= {req_chan.rect_right[CW-1], req_chan.rect_right}
                   - {req_chan.rect_left[CW-1], req_chan.rect_left};
         in_h_ff  <= {req_chan.rect_bottom[CW-1], req_chan.rect_bottom}
                   - {req_chan.rect_top[CW-1], req_chan.rect_top};
         in_sx_ff <= {req_chan.rect_right[CW-1], req_chan.rect_right}
                   + {req_chan.rect_left[CW-1], req_chan.rect_left};
         in_sy_ff <= {req_chan.rect_bottom[CW-1], req_chan.rect_bottom}
                   + {req_chan.rect_top[CW-1], req_chan.rect_top};
      end
   end

   // offsets and centre, truncated toward zero
   assign ox_prod = OPW'($signed(in_w_ff) * $signed(REBP_K_Q16));
   assign oy_prod = OPW'($signed(in_h_ff) * $signed(REBP_K_Q16));
   assign ox_adj  = ox_prod + (ox_prod[OPW-1] ? K_BIAS : '0);
   assign oy_adj  = oy_prod + (oy_prod[OPW-1] ? K_BIAS : '0);
   assign sx_adj  = in_sx_ff + DW'(in_sx_ff[DW-1]);
   assign sy_adj  = in_sy_ff + DW'(in_sy_ff[DW-1]);

   always_ff @(posedge clock) begin
      if (geo_free && in_vld_ff) begin
         geo_l_ff  <= in_l_ff;
         geo_t_ff  <= in_t_ff;
         geo_r_ff  <= in_r_ff;
         geo_b_ff  <= in_b_ff;
         geo_ox_ff <= ox_adj[REBP_K_FRAC +: DW];
         geo_oy_ff <= oy_adj[REBP_K_FRAC +: DW];
         geo_cx_ff <= sx_adj[DW-1:1];
         geo_cy_ff <= sy_adj[DW-1:1];
      end
   end

   // offsets of the current point from the centre
   always_comb begin
      lay = rebp_layout(seq_idx_ff);
      case (lay.xsel)
         XS_LEFT:  dx = {geo_l_ff[CW-1], geo_l_ff} - {geo_cx_ff[CW-1], geo_cx_ff};
         XS_CXM:   dx = '0 - geo_ox_ff;
         XS_CX:    dx = '0;
         XS_CXP:   dx = geo_ox_ff;
         XS_RIGHT: dx = {geo_r_ff[CW-1], geo_r_ff} - {geo_cx_ff[CW-1], geo_cx_ff};
         default:  dx = '0;
      endcase
      case (lay.ysel)
         YS_TOP:    dy = {geo_t_ff[CW-1], geo_t_ff} - {geo_cy_ff[CW-1], geo_cy_ff};
         YS_CYM:    dy = '0 - geo_oy_ff;
         YS_CY:     dy = '0;
         YS_CYP:    dy = geo_oy_ff;
         YS_BOTTOM: dy = {geo_b_ff[CW-1], geo_b_ff} - {geo_cy_ff[CW-1], geo_cy_ff};
         default:   dy = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pt_dx_ff <= dx;
         pt_dy_ff <= dy;
         pt_cx_ff <= geo_cx_ff;
         pt_cy_ff <= geo_cy_ff;
      end
   end

   rebp_rotate #(
      .COORD_WIDTH    (COORD_WIDTH),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_rotate (
      .clock    (clock),
      .reset    (reset),
      .rot_cos  (cos_ff),
      .rot_sin  (sin_ff),
      .pt_tag   (pt_tag_ff),
      .pt_dx    (pt_dx_ff),
      .pt_dy    (pt_dy_ff),
      .pt_cx    (pt_cx_ff),
      .pt_cy    (pt_cy_ff),
      .adv      (adv),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: hw/rtl/rebp_checker.sv
// ----------------------------------------------------------------------------
// rebp_checker
// port level checks on the control point response channel
// ----------------------------------------------------------------------------
`include "rotated_ellipse_bezier_points_defines.svh"

module rebp_checker
   import rebp_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [REBP_IDX_WIDTH-1:0] rsp_index,
   input logic                      rsp_last
);
   // index the next word should carry
   logic [REBP_IDX_WIDTH-1:0] exp_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_idx_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         exp_idx_ff <= rsp_last ? '0 : rsp_index + 1'b1;
      end
   end

   `REBP_ASSERT(a_index_order, rsp_valid |-> rsp_index == exp_idx_ff, "point index out of order")
   `REBP_ASSERT(a_last_flag, rsp_valid |-> rsp_last == (rsp_index == REBP_LAST_IDX), "last flag wrong")
   `REBP_ASSERT(a_stall_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index), "word dropped")
   `REBP_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "word after reset")

endmodule

bind rotated_ellipse_bezier_points rebp_checker u_rebp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_index (rsp_chan.point_index),
   .rsp_last  (rsp_chan.last_point)
);
